// ----- hw/rtl/msv_pkg.sv -----
// shared types, constants and constant tables of the sine voice
`default_nettype none

package msv_pkg;

    localparam int unsigned SAMPLE_RATE_HZ   = 48000;
    localparam int unsigned SINE_TABLE_DEPTH = 1024;
    localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned NOTE_COUNT       = 128;
    localparam int unsigned SEMITONES        = 12;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GAIN         = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_RELEASE_STEP = CFG_INDEX_W'(1);

    localparam logic [15:0] GAIN_RESET = 16'hFFFF;

    localparam logic [7:0] STATUS_MASK     = 8'hF0;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

    // 0.8 in Q0.24
    localparam logic [23:0] ENV_ON = 24'd13421773;

    localparam longint Q30 = 64'sd1073741824;

    localparam longint unsigned SAMPLE_RATE_L = 64'(SAMPLE_RATE_HZ);
    localparam longint unsigned STEP_ROUND    = 64'(SAMPLE_RATE_HZ / 2);
    localparam longint          SINE_DEPTH_L  = longint'(SINE_TABLE_DEPTH);

    // semitone frequencies of notes 60..71 in Q16 Hz, index 0 is note 60
    localparam logic [11:0][31:0] SEMITONE_Q16 = {
        32'd32367136, 32'd30550508, 32'd28835840, 32'd27217409,
        32'd25689813, 32'd24247955, 32'd22887021, 32'd21602472,
        32'd20390018, 32'd19245614, 32'd18165441, 32'd17145893
    };

    typedef enum logic [1:0] {
        CMD_NOTE_ON,
        CMD_NOTE_OFF,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] step;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } queue_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_rd_t;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] release_step;
    } voice_cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_MUL_ENV,
        BK_MUL_GAIN
    } back_state_t;

    function automatic logic [31:0] note_step_calc(input int unsigned oct,
                                                   input int unsigned k);
        longint unsigned   num;
        longint unsigned   q;
        num = 64'(SEMITONE_Q16[k]) << (oct + 11);
        q   = (num + STEP_ROUND) / SAMPLE_RATE_L;
        return q[31:0];
    endfunction

    function automatic logic [NOTE_COUNT-1:0][31:0] build_note_table();
        logic [NOTE_COUNT-1:0][31:0] t;
        t = '0;
        for (int oct = 0; oct * SEMITONES < NOTE_COUNT; oct++)
        begin
            for (int k = 0; k < SEMITONES; k++)
            begin
                if (oct * SEMITONES + k < NOTE_COUNT)
                begin
                    t[oct * SEMITONES + k] = note_step_calc(oct, k);
                end
            end
        end
        return t;
    endfunction

    // quarter-wave odd polynomial in Q30, rounded to Q1.15
    function automatic logic [15:0] sine_entry(input longint idx);
        longint p;
        longint quad;
        longint r;
        longint z;
        longint z2;
        longint poly;
        longint s;
        p    = (idx <<< 32) / SINE_DEPTH_L;
        quad = p >>> 30;
        r    = p & 64'sh3FFF_FFFF;
        if (quad[0])
        begin
            r = Q30 - r;
        end
        z    = r;
        z2   = (z * z) / Q30;
        poly = 64'sd172272;
        poly = -64'sd5026995 + (poly * z2) / Q30;
        poly = 64'sd85569306 + (poly * z2) / Q30;
        poly = -64'sd693598667 + (poly * z2) / Q30;
        poly = 64'sd1686629713 + (poly * z2) / Q30;
        s    = (z * poly) / Q30;
        if (s < 0)
        begin
            s = 0;
        end
        s = (s + 64'sd16384) / 64'sd32768;
        if (s > 64'sd32767)
        begin
            s = 64'sd32767;
        end
        if (quad[1])
        begin
            s = -s;
        end
        return s[15:0];
    endfunction

    function automatic logic [SINE_TABLE_DEPTH-1:0][15:0] build_sine_table();
        logic [SINE_TABLE_DEPTH-1:0][15:0] t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            t[i] = sine_entry(longint'(i));
        end
        return t;
    endfunction

    localparam logic [NOTE_COUNT-1:0][31:0]       NOTE_STEP_TABLE = build_note_table();
    localparam logic [SINE_TABLE_DEPTH-1:0][15:0] SINE_TABLE      = build_sine_table();

endpackage

`default_nettype wire

// ----- hw/rtl/msv_if.sv -----
// channel interfaces of the sine voice: input items, samples, register writes
`default_nettype none

interface msv_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] status_byte;
    logic [6:0] note_byte;
    logic [6:0] velocity_byte;

    modport source (output valid, action, status_byte, note_byte, velocity_byte,
                    input ready);
    modport sink   (input valid, action, status_byte, note_byte, velocity_byte,
                    output ready);
endinterface

interface msv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

interface msv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [msv_pkg::CFG_INDEX_W-1:0]    index;
    logic [msv_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/midi_sine_voice_top.sv -----
// Monophonic sine voice. Each input word is a midi message or a sample tick;
// the front end decodes it in the cycle it is taken and drops it into a
// two-entry command queue, so a new word is taken every cycle while the queue
// has room. The voice engine handles a note message in its idle state and
// runs one tick at a time through phase add, registered sine table read,
// envelope multiply and gain multiply, stalling while the output is full.
// Each tick gives one sample word from an output register that holds it until
// taken; messages give none. Registers gain (index 0) and release_step
// (index 1) are written through the cfg channel, which is always ready, and
// should be written only while the voice is idle.
`default_nettype none

module midi_sine_voice_top (
    input  logic        clk,
    input  logic        rst_n,
    msv_in_if.sink      item,
    msv_out_if.source   result,
    msv_cfg_if.sink     cfg
);

    logic [15:0]         gain_reg, gain_next;
    logic [15:0]         release_step_reg, release_step_next;
    msv_pkg::voice_cfg_t voice_cfg;
    msv_pkg::queue_wr_t  q_wr;
    msv_pkg::queue_rd_t  q_rd;
    logic                q_full;
    logic                q_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        gain_next         = gain_reg;
        release_step_next = release_step_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                msv_pkg::CFG_IDX_GAIN:         gain_next         = cfg.data;
                msv_pkg::CFG_IDX_RELEASE_STEP: release_step_next = cfg.data;
                default:
                begin
                    gain_next         = gain_reg;
                    release_step_next = release_step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= msv_pkg::GAIN_RESET;
            release_step_reg <= '0;
        end
        else
        begin
            gain_reg         <= gain_next;
            release_step_reg <= release_step_next;
        end
    end

    assign voice_cfg.gain         = gain_reg;
    assign voice_cfg.release_step = release_step_reg;

    msv_front u_front (
        .item       (item),
        .queue_full (q_full),
        .wr         (q_wr)
    );

    msv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .rd    (q_rd),
        .full  (q_full)
    );

    msv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (q_rd),
        .cfg    (voice_cfg),
        .pop    (q_pop),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/msv_front.sv -----
// front end: accepts words, decodes midi status, looks up the note step
`default_nettype none

module msv_front (
    msv_in_if.sink              item,
    input  logic                queue_full,
    output msv_pkg::queue_wr_t  wr
);

    logic [7:0] status_hi;
    logic       known;

    assign status_hi = item.status_byte & msv_pkg::STATUS_MASK;

    always_comb
    begin
        wr.cmd.step = msv_pkg::NOTE_STEP_TABLE[item.note_byte];
        wr.cmd.kind = msv_pkg::CMD_TICK;
        known       = 1'b0;
        priority if (item.action)
        begin
            wr.cmd.kind = msv_pkg::CMD_TICK;
            known       = 1'b1;
        end
        else if (status_hi == msv_pkg::STATUS_NOTE_OFF ||
                 (status_hi == msv_pkg::STATUS_NOTE_ON && item.velocity_byte == 7'd0))
        begin
            wr.cmd.kind = msv_pkg::CMD_NOTE_OFF;
            known       = 1'b1;
        end
        else if (status_hi == msv_pkg::STATUS_NOTE_ON)
        begin
            wr.cmd.kind = msv_pkg::CMD_NOTE_ON;
            known       = 1'b1;
        end
        else
        begin
            known = 1'b0;
        end
    end

    // other statuses are taken and dropped here
    assign item.ready = !queue_full;
    assign wr.push    = item.valid && !queue_full && known;

endmodule

`default_nettype wire

// ----- hw/rtl/msv_queue.sv -----
// short command queue between the front end and the voice engine
`default_nettype none

module msv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  msv_pkg::queue_wr_t  wr,
    input  logic                pop,
    output msv_pkg::queue_rd_t  rd,
    output logic                full
);

    msv_pkg::cmd_t slot_reg [msv_pkg::QUEUE_DEPTH];

    logic [msv_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [msv_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [msv_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            do_pop;

    localparam logic [msv_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        msv_pkg::QUEUE_PTR_W'(msv_pkg::QUEUE_DEPTH - 1);
    localparam logic [msv_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        msv_pkg::QUEUE_CNT_W'(msv_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == FULL_COUNT);
    assign rd.valid = (count_reg != '0);
    assign rd.cmd   = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slot_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/msv_back.sv -----
// voice engine: phase accumulator, sine lookup, envelope and gain, sample word
`default_nettype none

module msv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  msv_pkg::queue_rd_t  rd,
    input  msv_pkg::voice_cfg_t cfg,
    output logic                pop,
    msv_out_if.source           result
);

    typedef struct packed {
        logic load_note;
        logic clear_env;
        logic start_tick;
        logic lookup;
        logic mul_env;
        logic emit;
    } back_ctrl_t;

    msv_pkg::back_state_t state_reg, state_next;
    back_ctrl_t           ctrl;

    logic [31:0] phase_acc_reg, phase_acc_next;
    logic [31:0] phase_step_reg, phase_step_next;
    logic [23:0] env_reg, env_next;
    logic [15:0] sine_reg;
    logic        neg_reg;
    logic [38:0] mag_env_reg;
    logic [15:0] sample_reg, sample_next;
    logic        valid_reg, valid_next;

    logic        slot_free;
    logic [63:0] phase_scaled;
    logic [msv_pkg::SINE_IDX_W-1:0] sine_idx;
    logic [15:0] sine_mag;
    logic [38:0] mag_env_next;
    logic [54:0] prod_full;
    logic [15:0] mag_out;
    logic [23:0] env_decay;

    assign slot_free = !valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msv_pkg::BK_IDLE:
            begin
                if (rd.valid && rd.cmd.kind == msv_pkg::CMD_TICK)
                begin
                    state_next = msv_pkg::BK_LOOKUP;
                end
            end
            msv_pkg::BK_LOOKUP:   state_next = msv_pkg::BK_MUL_ENV;
            msv_pkg::BK_MUL_ENV:  state_next = msv_pkg::BK_MUL_GAIN;
            msv_pkg::BK_MUL_GAIN:
            begin
                if (slot_free)
                begin
                    state_next = msv_pkg::BK_IDLE;
                end
            end
            default:              state_next = msv_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        pop  = 1'b0;
        unique case (state_reg)
            msv_pkg::BK_IDLE:
            begin
                pop = rd.valid;
                if (rd.valid)
                begin
                    unique case (rd.cmd.kind)
                        msv_pkg::CMD_NOTE_ON:  ctrl.load_note  = 1'b1;
                        msv_pkg::CMD_NOTE_OFF: ctrl.clear_env  = 1'b1;
                        msv_pkg::CMD_TICK:     ctrl.start_tick = 1'b1;
                        default:               ctrl            = '0;
                    endcase
                end
            end
            msv_pkg::BK_LOOKUP:   ctrl.lookup  = 1'b1;
            msv_pkg::BK_MUL_ENV:  ctrl.mul_env = 1'b1;
            msv_pkg::BK_MUL_GAIN: ctrl.emit    = slot_free;
            default:              ctrl         = '0;
        endcase
    end

    // table index = floor(phase * depth / 2^32)
    assign phase_scaled = {32'd0, phase_acc_reg} * 64'(msv_pkg::SINE_TABLE_DEPTH);
    assign sine_idx     = phase_scaled[32 +: msv_pkg::SINE_IDX_W];

    // table magnitude never exceeds 32767, so 15 bits carry it
    assign sine_mag     = sine_reg[15] ? (~sine_reg + 16'd1) : sine_reg;
    assign mag_env_next = {24'd0, sine_mag[14:0]} * {15'd0, env_reg};
    assign env_decay    = (env_reg > {8'd0, cfg.release_step})
                        ? env_reg - {8'd0, cfg.release_step} : 24'd0;

    // product stays below 2^55, so the magnitude fits in 15 bits
    assign prod_full = {16'd0, mag_env_reg} * {39'd0, cfg.gain};
    assign mag_out   = {1'b0, prod_full[54:40]};

    always_comb
    begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        env_next        = env_reg;
        if (ctrl.load_note)
        begin
            phase_step_next = rd.cmd.step;
            env_next        = msv_pkg::ENV_ON;
        end
        if (ctrl.clear_env)
        begin
            env_next = 24'd0;
        end
        if (ctrl.start_tick)
        begin
            phase_acc_next = phase_acc_reg + phase_step_reg;
        end
        if (ctrl.mul_env)
        begin
            env_next = env_decay;
        end
    end

    always_comb
    begin
        sample_next = neg_reg ? (~mag_out + 16'd1) : mag_out;
        valid_next  = valid_reg;
        if (ctrl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msv_pkg::BK_IDLE;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            env_reg        <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            env_reg        <= env_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lookup)
        begin
            sine_reg <= msv_pkg::SINE_TABLE[sine_idx];
        end
        if (ctrl.mul_env)
        begin
            neg_reg     <= sine_reg[15];
            mag_env_reg <= mag_env_next;
        end
        if (ctrl.emit)
        begin
            sample_reg <= sample_next;
        end
    end

    assign result.valid  = valid_reg;
    assign result.sample = sample_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/msv_checker.sv -----
// port-level checker of the sine voice and its bind to the top level
`default_nettype none

module msv_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        item_action,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [15:0] result_sample
);

    localparam int unsigned OWED_MAX = msv_pkg::QUEUE_DEPTH + 2;
    localparam int unsigned OWED_W   = $clog2(OWED_MAX + 2);

    // ticks taken whose sample word is not yet delivered
    logic [OWED_W-1:0] owed_reg, owed_next;
    logic              tick_in;
    logic              word_out;

    assign tick_in  = item_valid && item_ready && item_action;
    assign word_out = result_valid && result_ready;

    always_comb
    begin
        owed_next = owed_reg;
        if (tick_in && !word_out)
        begin
            owed_next = owed_reg + 1'b1;
        end
        else if (word_out && !tick_in)
        begin
            owed_next = owed_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_sample))
        else $error("sample word changed or dropped while stalled");

    a_no_extra_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> owed_reg != '0)
        else $error("sample word without a pending tick");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= OWED_W'(OWED_MAX))
        else $error("more ticks in flight than queue and engine can hold");

endmodule

bind midi_sine_voice_top msv_checker u_msv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .item_action   (item.action),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_sample (result.sample)
);

`default_nettype wire
